### rtl/bmsp_pkg.sv
// Shared types, constants and helper functions for the bus memory and serial port block.
package bmsp_pkg;

    localparam int MEMORY_BYTES = 65536;
    localparam int QUEUE_DEPTH  = 8;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int CMD_W   = 3;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // The memory depth is a power of two, so the low address bits index it.
    localparam int MEM_AW  = $clog2(MEMORY_BYTES);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] IO_BASE_RESET = 16'hE000;
    localparam logic [CFG_W-1:0] RAM_TOP_RESET = 16'hEFFF;

    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_RX_PUSH = 3'd2,
        CMD_TX_POP  = 3'd3,
        CMD_PRELOAD = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IO_BASE = 1'b0,
        REG_RAM_TOP = 1'b1
    } t_reg_idx;

    localparam t_qcnt Q_FULL = QCNT_W'(QUEUE_DEPTH);

    // Slot that follows the last stored entry, wrapping round the queue.
    function automatic t_qptr q_tail(t_qptr head, t_qcnt count);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W + 1)'(head) + (QCNT_W + 1)'(count);
        if (sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCNT_W + 1)'(QUEUE_DEPTH);
        end
        return QPTR_W'(sum);
    endfunction

    // Head pointer after one pop.
    function automatic t_qptr q_next(t_qptr head);
        t_qptr nxt;
        if (head == QPTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = head + 1'b1;
        end
        return nxt;
    endfunction

endpackage

### rtl/bmsp_in_if.sv
// Valid/ready channel carrying one bus command into the block.
interface bmsp_in_if;
    import bmsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output cmd, output address, output data, input ready);
    modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

### rtl/bmsp_out_if.sv
// Valid/ready channel carrying one result out of the block.
interface bmsp_out_if;
    import bmsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              data_valid;
    logic              dropped;

    modport source (output valid, output read_data, output data_valid, output dropped,
                    input ready);
    modport sink   (input valid, input read_data, input data_valid, input dropped,
                    output ready);
endinterface

### rtl/bmsp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/bus_memory_and_serial_port_top.sv
// Top level: CPU bus slave with a byte memory and a two-queue serial port.
//
// This block answers one bus command per transfer on the input channel and returns exactly
// one result per command on the output channel, the cycle after the command is taken; a new
// command may be taken in every cycle while the output side keeps up. Each command makes at
// most one access to the single memory array, whose registered read port supplies memory
// reads. A CPU read at the I/O base returns the status byte (bit 0: receive data waiting,
// bit 1: transmit queue has room); a read one address higher pops the receive queue and
// gives data_valid low when that queue is empty; any other read returns memory. A CPU write
// one above the I/O base pushes to the transmit queue, other CPU writes at or below the RAM
// top store to memory (the status address excepted), and higher addresses are read-only.
// The host pushes received bytes, pops transmit bytes and preloads any memory address. A
// push into a full queue discards the byte and reports dropped. After reset the memory is
// cleared to zero by a pass that writes every memory address, during which ready stays low;
// configuration writes are taken at any time, but should only be made while the block is
// idle. Configuration register 0 is the I/O base, register 1 the RAM top.
module bus_memory_and_serial_port_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bmsp_in_if.sink                            i_in,
    bmsp_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [bmsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmsp_pkg::CFG_W-1:0]         i_cfg_data
);
    import bmsp_pkg::*;

    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEMORY_BYTES - 1);

    // Configuration registers.
    logic [CFG_W-1:0] r_io_base;
    logic [CFG_W-1:0] r_ram_top;

    // Memory clearing pass after reset.
    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_addr;

    // Serial port queues; the contents need no reset, the counts say what is valid.
    logic [DATA_W-1:0] r_rx_q [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_tx_q [QUEUE_DEPTH];
    t_qptr             r_rx_head, r_tx_head;
    t_qcnt             r_rx_count, r_tx_count;

    // Result register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic              r_data_valid;
    logic              r_dropped;
    logic              r_mem_sel;

    // Decode of the command being taken.
    logic              accept;
    logic [ADDR_W-1:0] data_addr;
    logic              is_status;
    logic              is_data;
    logic              rx_empty, rx_full, tx_empty, tx_full;
    logic              rx_push, rx_pop, tx_push, tx_pop;
    logic              mem_we, mem_re;
    logic [DATA_W-1:0] n_read_data;
    logic              n_data_valid;
    logic              n_dropped;

    // Memory port.
    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign i_in.ready = !r_clr_busy && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    // The data register sits one above the status register and wraps at the top.
    assign data_addr = r_io_base + 1'b1;
    assign is_status = (i_in.address == r_io_base);
    assign is_data   = (i_in.address == data_addr);

    assign rx_empty = (r_rx_count == '0);
    assign rx_full  = (r_rx_count == Q_FULL);
    assign tx_empty = (r_tx_count == '0);
    assign tx_full  = (r_tx_count == Q_FULL);

    always_comb begin
        rx_push      = 1'b0;
        rx_pop       = 1'b0;
        tx_push      = 1'b0;
        tx_pop       = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        n_read_data  = '0;
        n_data_valid = 1'b0;
        n_dropped    = 1'b0;
        unique case (i_in.cmd)
            CMD_READ: begin
                if (is_status) begin
                    n_read_data  = {{(DATA_W - 2){1'b0}}, !tx_full, !rx_empty};
                    n_data_valid = 1'b1;
                end else if (is_data) begin
                    if (!rx_empty) begin
                        rx_pop       = 1'b1;
                        n_read_data  = r_rx_q[r_rx_head];
                        n_data_valid = 1'b1;
                    end
                end else begin
                    mem_re       = 1'b1;
                    n_data_valid = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (is_data) begin
                    if (tx_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        tx_push = 1'b1;
                    end
                end else if (i_in.address <= r_ram_top && !is_status) begin
                    mem_we = 1'b1;
                end
            end
            CMD_RX_PUSH: begin
                if (rx_full) begin
                    n_dropped = 1'b1;
                end else begin
                    rx_push = 1'b1;
                end
            end
            CMD_TX_POP: begin
                if (!tx_empty) begin
                    tx_pop       = 1'b1;
                    n_read_data  = r_tx_q[r_tx_head];
                    n_data_valid = 1'b1;
                end
            end
            CMD_PRELOAD: begin
                mem_we = 1'b1;
            end
            default: begin
                // Unused commands leave everything alone and give an all-zero result.
            end
        endcase
    end

    // The clearing pass owns the write port until it finishes; no command is taken then.
    assign ram_we    = r_clr_busy || (accept && mem_we);
    assign ram_waddr = r_clr_busy ? r_clr_addr : i_in.address[MEM_AW-1:0];
    assign ram_wdata = r_clr_busy ? '0 : i_in.data;

    bmsp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept && mem_re),
        .i_raddr (i_in.address[MEM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_io_base <= IO_BASE_RESET;
            r_ram_top <= RAM_TOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IO_BASE: r_io_base <= i_cfg_data;
                REG_RAM_TOP: r_ram_top <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MEM_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Queue storage: written at the tail on a push, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept && rx_push) begin
            r_rx_q[q_tail(r_rx_head, r_rx_count)] <= i_in.data;
        end
        if (accept && tx_push) begin
            r_tx_q[q_tail(r_tx_head, r_tx_count)] <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head  <= '0;
            r_rx_count <= '0;
            r_tx_head  <= '0;
            r_tx_count <= '0;
        end else if (accept) begin
            if (rx_push) begin
                r_rx_count <= r_rx_count + 1'b1;
            end else if (rx_pop) begin
                r_rx_count <= r_rx_count - 1'b1;
                r_rx_head  <= q_next(r_rx_head);
            end
            if (tx_push) begin
                r_tx_count <= r_tx_count + 1'b1;
            end else if (tx_pop) begin
                r_tx_count <= r_tx_count - 1'b1;
                r_tx_head  <= q_next(r_tx_head);
            end
        end
    end

    // Result stage: the memory's own read register supplies memory reads, and it only
    // changes when a new command is taken, so a stalled result holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data  <= n_read_data;
            r_data_valid <= n_data_valid;
            r_dropped    <= n_dropped;
            r_mem_sel    <= mem_re;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_mem_sel ? ram_rdata : r_read_data;
    assign o_out.data_valid = r_data_valid;
    assign o_out.dropped    = r_dropped;
endmodule

### rtl/bmsp_checker.sv
// Port-level checker for the bus memory and serial port block, with its bind statement.
module bmsp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic [bmsp_pkg::CMD_W-1:0]   i_in_cmd,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bmsp_pkg::DATA_W-1:0]  i_out_read_data,
    input logic                         i_out_data_valid,
    input logic                         i_out_dropped
);
    import bmsp_pkg::*;

    logic in_acc;
    logic no_read_cmd;

    assign in_acc      = i_in_valid && i_in_ready;
    assign no_read_cmd = (i_in_cmd == CMD_WRITE) || (i_in_cmd == CMD_RX_PUSH) ||
                         (i_in_cmd == CMD_PRELOAD);

    // Every command taken produces a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid)
        else $error("no result after an accepted command");

    // A result never carries data and reports a lost byte at once.
    a_valid_or_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data_valid && i_out_dropped))
        else $error("result both valid data and dropped");

    // Commands that return nothing give no valid data.
    a_no_data_on_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && no_read_cmd) |=> !i_out_data_valid)
        else $error("write or push returned valid data");

    // A stalled result holds its data.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_read_data)))
        else $error("stalled result changed");
endmodule

bind bus_memory_and_serial_port_top bmsp_checker u_bmsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_cmd         (i_in.cmd),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_read_data  (o_out.read_data),
    .i_out_data_valid (o_out.data_valid),
    .i_out_dropped    (o_out.dropped)
);
